[rtl/tti_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types and constants for the streaming text-to-integer parser.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int unsigned VALUE_W  = 32;  // accumulator width, value wraps here
  localparam int unsigned NUMBER_W = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned BASE_W   = 6;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SELECT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UC_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UC_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              start_req;
  } item_t;

  typedef struct packed {
    logic [BASE_W-1:0] base_select;
    logic              signed_mode;
  } cfg_t;

endpackage

[rtl/tti_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_in_stage
// Input register: captures one character beat and holds it until the parse
// engine takes it.
// ----------------------------------------------------------------------------
module tti_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tti_pkg::item_t in_item,
  output logic           hold_valid,
  output tti_pkg::item_t hold_item,
  input  logic           take
);

  logic valid_next;

  // room when empty or when the held beat leaves this cycle
  assign in_ready = !hold_valid || take;

  always_comb begin
    valid_next = hold_valid;
    if (in_ready) begin
      valid_next = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= valid_next;
    end
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

[rtl/tti_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_engine
// Parse state, one-character next-state logic and the result register.
// ----------------------------------------------------------------------------
module tti_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  tti_pkg::cfg_t                  cfg,
  input  logic                           hold_valid,
  input  tti_pkg::item_t                 hold_item,
  output logic                           take,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tti_pkg::NUMBER_W-1:0]   number,
  output logic [tti_pkg::COUNT_W-1:0]    consumed
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIGN_WS,
    PH_PLUS_WS,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  phase_t                           phase, phase_next;
  logic [tti_pkg::BASE_W-1:0]       work_base, work_base_next;
  logic [tti_pkg::VALUE_W-1:0]      acc, acc_next;
  logic [tti_pkg::COUNT_W-1:0]      char_count, char_count_next;
  logic                             minus_seen, minus_seen_next;
  logic                             emit;
  logic [tti_pkg::VALUE_W-1:0]      value;
  logic                             advance;

  // digit decode: letters count from ten
  logic [tti_pkg::CHAR_W-1:0] c;
  logic                       is_blank;
  logic                       digit_ok;
  logic [tti_pkg::BASE_W-1:0] digit;

  assign c = hold_item.ch;
  assign is_blank = (c == tti_pkg::CH_SPACE) ||
                    (c >= tti_pkg::CH_TAB && c <= tti_pkg::CH_CR);

  always_comb begin
    digit_ok = 1'b1;
    digit    = '0;
    if (c >= tti_pkg::CH_ZERO && c <= tti_pkg::CH_NINE) begin
      digit = tti_pkg::BASE_W'(c - tti_pkg::CH_ZERO);
    end else if (c >= tti_pkg::CH_LC_A && c <= tti_pkg::CH_LC_Z) begin
      digit = tti_pkg::BASE_W'(c - tti_pkg::CH_LC_A) + 6'd10;
    end else if (c >= tti_pkg::CH_UC_A && c <= tti_pkg::CH_UC_Z) begin
      digit = tti_pkg::BASE_W'(c - tti_pkg::CH_UC_A) + 6'd10;
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign advance = !out_valid || out_ready;
  assign take    = hold_valid && advance;

  always_comb begin
    phase_t                        ph;
    logic [tti_pkg::BASE_W-1:0]    wb;
    logic [tti_pkg::VALUE_W-1:0]   acc_in;
    logic [tti_pkg::COUNT_W-1:0]   cnt_in;
    logic                          minus;
    logic                          go_prefix;
    logic                          go_zero;
    logic                          go_digits;
    logic [1:0]                    inc;
    logic [tti_pkg::COUNT_W:0]     cnt_sum;

    ph        = phase;
    wb        = work_base;
    acc_in    = acc;
    cnt_in    = char_count;
    minus     = minus_seen;
    go_prefix = 1'b0;
    go_zero   = 1'b0;
    go_digits = 1'b0;
    inc       = 2'd0;
    emit      = 1'b0;

    if (hold_item.start_req) begin
      ph     = cfg.signed_mode ? PH_SIGN_WS : PH_PLUS_WS;
      wb     = cfg.base_select;
      acc_in = '0;
      cnt_in = '0;
      minus  = 1'b0;
    end

    unique case (ph)
      PH_IDLE: begin
        // ignore characters until the next start
      end
      PH_SIGN_WS: begin
        if (is_blank) begin
          inc = 2'd1;
        end else if (c == tti_pkg::CH_MINUS || c == tti_pkg::CH_PLUS) begin
          minus = (c == tti_pkg::CH_MINUS);
          inc   = 2'd1;
          ph    = PH_PLUS_WS;
        end else begin
          go_prefix = 1'b1;
        end
      end
      PH_PLUS_WS: begin
        if (is_blank) begin
          inc = 2'd1;
        end else if (c == tti_pkg::CH_PLUS) begin
          inc = 2'd1;
          ph  = PH_PREFIX;
        end else begin
          go_prefix = 1'b1;
        end
      end
      PH_PREFIX: go_prefix = 1'b1;
      PH_ZERO:   go_zero   = 1'b1;
      PH_DIGITS: go_digits = 1'b1;
      default:   ph        = PH_IDLE;
    endcase

    if (go_prefix) begin
      if ((wb == tti_pkg::BASE_AUTO || wb == tti_pkg::BASE_HEX) &&
          c == tti_pkg::CH_ZERO) begin
        // hold the zero until we know whether an 'x' follows
        ph = PH_ZERO;
      end else begin
        if (wb == tti_pkg::BASE_AUTO) begin
          wb = tti_pkg::BASE_DEC;
        end
        ph        = PH_DIGITS;
        go_digits = 1'b1;
      end
    end

    if (go_zero) begin
      ph = PH_DIGITS;
      if (c == tti_pkg::CH_LC_X || c == tti_pkg::CH_UC_X) begin
        wb  = tti_pkg::BASE_HEX;
        inc = 2'd2;
      end else begin
        if (wb == tti_pkg::BASE_AUTO) begin
          wb = tti_pkg::BASE_OCT;
        end
        // the held zero is digit zero: value stays zero
        inc       = 2'd1;
        go_digits = 1'b1;
      end
    end

    if (go_digits) begin
      if (digit_ok && digit < wb) begin
        acc_in = acc_in * tti_pkg::VALUE_W'(wb) + tti_pkg::VALUE_W'(digit);
        inc    = inc + 2'd1;
      end else begin
        emit = 1'b1;
        ph   = PH_IDLE;
      end
    end

    cnt_sum = {1'b0, cnt_in} + (tti_pkg::COUNT_W + 1)'(inc);
    // saturate the count
    char_count_next = cnt_sum[tti_pkg::COUNT_W] ? '1 : cnt_sum[tti_pkg::COUNT_W-1:0];
    phase_next      = ph;
    work_base_next  = wb;
    acc_next        = acc_in;
    minus_seen_next = minus;
  end

  assign value = minus_seen_next ? (tti_pkg::VALUE_W'(0) - acc_next) : acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      work_base  <= '0;
      acc        <= '0;
      char_count <= '0;
      minus_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        phase      <= phase_next;
        work_base  <= work_base_next;
        acc        <= acc_next;
        char_count <= char_count_next;
        minus_seen <= minus_seen_next;
      end
      if (advance) begin
        out_valid <= take && emit;
      end
    end
    if (take && emit) begin
      number   <= tti_pkg::NUMBER_W'(value);
      consumed <= char_count_next;
    end
  end

endmodule

[rtl/text_to_integer_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming strtoul/strtol-style integer parser, one character per beat.
// ----------------------------------------------------------------------------
// Send one character per beat on the input channel, with start_req set on the
// first character of each conversion. The block takes one character every
// cycle while results are drained; each character passes an input register
// and a parse step (one 32x6 multiply-add on the accumulator); a result is
// registered on the output once its stop character is parsed and the result
// side is free. At most one result (value and count of consumed characters)
// comes out per conversion, on the first character that does not fit the
// number; characters after it are dropped until the next start. base_select
// and signed_mode are sampled at each start and should only be written while
// no conversion is in flight.
module text_to_integer_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tti_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tti_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tti_pkg::CHAR_W-1:0]          ch,
  input  logic                                start_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tti_pkg::NUMBER_W-1:0]        number,
  output logic [tti_pkg::COUNT_W-1:0]         consumed
);

  tti_pkg::cfg_t  cfg;
  tti_pkg::item_t in_item;
  tti_pkg::item_t hold_item;
  logic           hold_valid;
  logic           take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_select <= tti_pkg::BASE_RESET;
      cfg.signed_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tti_pkg::CFG_BASE_SELECT: cfg.base_select <= cfg_data;
        tti_pkg::CFG_SIGNED_MODE: cfg.signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_item.ch        = ch;
  assign in_item.start_req = start_req;

  tti_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take)
  );

  tti_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .number     (number),
    .consumed   (consumed)
  );

endmodule

[rtl/tti_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_assertions
// Port-level checks for the text-to-integer parser, bound to the top level.
// ----------------------------------------------------------------------------
module tti_assertions (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tti_pkg::NUMBER_W-1:0]   number,
  input logic [tti_pkg::COUNT_W-1:0]    consumed
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(number) && $stable(consumed))
    else $error("result beat changed while stalled");

  // input side never stalls while the result side is free
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with result side free");

  // reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

  // a new result never rises straight out of reset
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(rst))
    else $error("result raised straight out of reset");

endmodule

bind text_to_integer_parser tti_assertions u_tti_assertions (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .number    (number),
  .consumed  (consumed)
);

[sim/tti_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_checker
// Watches the character and result channels of the text-to-integer parser,
// predicts each parsed value and consumed count from the accepted characters
// and the register writes, and compares every result beat in order.
// ----------------------------------------------------------------------------
module tti_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tti_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [tti_pkg::CHAR_W-1:0]     ch,
  input  logic                           start_req,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [tti_pkg::NUMBER_W-1:0]   number,
  input  logic [tti_pkg::COUNT_W-1:0]    consumed,
  output int                             fail_count,
  output int                             outstanding
);
  import tti_pkg::*;

  localparam logic [CHAR_W-1:0] NO_DIGIT = 8'hFF;

  typedef enum logic [2:0] {
    P_IDLE, P_SIGN_WS, P_PLUS_WS, P_PREFIX, P_ZERO, P_DIGITS
  } parse_phase_e;

  typedef struct packed {
    logic [NUMBER_W-1:0] number;
    logic [COUNT_W-1:0]  consumed;
  } parse_result_t;

  // register copies
  logic [BASE_W-1:0]   cfg_base;
  logic                cfg_signed;

  // parser state
  parse_phase_e        phase_q;
  logic [BASE_W-1:0]   base_q;
  logic [VALUE_W-1:0]  acc_q;
  logic [COUNT_W-1:0]  count_q;
  logic                minus_q;

  parse_result_t       expected_results[$];

  function automatic logic is_blank(logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_value(logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LC_A && c <= CH_LC_Z) return c - CH_LC_A + 8'd10;
    if (c >= CH_UC_A && c <= CH_UC_Z) return c - CH_UC_A + 8'd10;
    return NO_DIGIT;
  endfunction

  function automatic void bump_count();
    if (count_q != '1) count_q = count_q + 1'b1;
  endfunction

  // Advance the parser by one character; emit is set on the stop character.
  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic st,
                            output logic emit, output parse_result_t res);
    logic              done;
    logic [CHAR_W-1:0] d;
    emit = 1'b0;
    res  = '0;
    done = 1'b0;
    if (st) begin
      acc_q   = '0;
      count_q = '0;
      minus_q = 1'b0;
      base_q  = cfg_base;
      phase_q = cfg_signed ? P_SIGN_WS : P_PLUS_WS;
    end
    while (!done) begin
      case (phase_q)
        P_SIGN_WS: begin
          if (is_blank(c)) begin
            bump_count();
            done = 1'b1;
          end else begin
            phase_q = P_PLUS_WS;
            if (c == CH_MINUS || c == CH_PLUS) begin
              minus_q = (c == CH_MINUS);
              bump_count();
              done = 1'b1;
            end
          end
        end
        P_PLUS_WS: begin
          if (is_blank(c)) begin
            bump_count();
            done = 1'b1;
          end else begin
            phase_q = P_PREFIX;
            if (c == CH_PLUS) begin
              bump_count();
              done = 1'b1;
            end
          end
        end
        P_PREFIX: begin
          if ((base_q == BASE_AUTO || base_q == BASE_HEX) && c == CH_ZERO) begin
            // hold the zero until we know whether an x follows
            phase_q = P_ZERO;
            done = 1'b1;
          end else begin
            if (base_q == BASE_AUTO) base_q = BASE_DEC;
            phase_q = P_DIGITS;
          end
        end
        P_ZERO: begin
          phase_q = P_DIGITS;
          if (c == CH_LC_X || c == CH_UC_X) begin
            base_q = BASE_HEX;
            bump_count();
            bump_count();
            done = 1'b1;
          end else begin
            if (base_q == BASE_AUTO) base_q = BASE_OCT;
            bump_count();
          end
        end
        P_DIGITS: begin
          d = digit_value(c);
          if (d < base_q) begin
            acc_q = acc_q * base_q + d;
            bump_count();
          end else begin
            emit = 1'b1;
            res.number   = minus_q ? (32'd0 - acc_q) : acc_q;
            res.consumed = count_q;
            phase_q = P_IDLE;
          end
          done = 1'b1;
        end
        default: begin
          phase_q = P_IDLE;
          done = 1'b1;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    parse_result_t res;
    parse_result_t want;
    logic          emit;
    if (rst) begin
      cfg_base   = BASE_RESET;
      cfg_signed = 1'b0;
      phase_q    = P_IDLE;
      base_q     = '0;
      acc_q      = '0;
      count_q    = '0;
      minus_q    = 1'b0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_SELECT: cfg_base   = cfg_data[BASE_W-1:0];
          CFG_SIGNED_MODE: cfg_signed = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        parse_char(ch, start_req, emit, res);
        if (emit) expected_results.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got number %h consumed %0d",
                   $time, number, consumed);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (number !== want.number) begin
            $display("%0t: number mismatch: expected %h, got %h",
                     $time, want.number, number);
            fail_count++;
          end
          if (consumed !== want.consumed) begin
            $display("%0t: consumed mismatch: expected %0d, got %0d",
                     $time, want.consumed, consumed);
            fail_count++;
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the text-to-integer parser: directed strings covering signs,
// prefixes, bases and wrap, then random conversions and noise over several
// register settings and idle/stall mixes. The checker instance does the
// prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import tti_pkg::*;

  localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3B;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CHAR_W-1:0]     ch;
  logic                  start_req;
  logic                  out_valid;
  logic                  out_ready;
  logic [NUMBER_W-1:0]   number;
  logic [COUNT_W-1:0]    consumed;
  int                    fail_count;
  int                    outstanding;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int chars_sent     = 0;

  text_to_integer_parser u_dut (.*);
  tti_checker            u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL text_to_integer_parser");
    $finish;
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Valid stays high after a beat; the next call lowers it only for a gap.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic st);
    int gap;
    gap = 0;
    chars_sent++;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    ch        <= c;
    start_req <= st;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  // Drop valid, then wait out every expected result and the pipeline.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reconfigure(input logic [BASE_W-1:0] base, input logic sgn);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_SELECT;
    cfg_data  <= CFG_DATA_W'(base);
    @(negedge clk);
    cfg_index <= CFG_SIGNED_MODE;
    cfg_data  <= CFG_DATA_W'(sgn);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] pick_blank();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? CH_SPACE : CH_TAB + CHAR_W'(k);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(int v);
    if (v < 10) return CH_ZERO + CHAR_W'(v);
    return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + CHAR_W'(v - 10);
  endfunction

  // Conversion with random content, a random final byte and sometimes trailing
  // bytes, which the block drops once the number has ended.
  task automatic send_conversion(input logic [BASE_W-1:0] base, input logic sgn);
    logic [CHAR_W-1:0] text[$];
    int                eff_base;
    int                n;
    int                v;
    int                style;
    repeat ($urandom_range(2)) text.push_back(pick_blank());
    if (sgn && $urandom_range(1)) begin
      text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      repeat ($urandom_range(1)) text.push_back(pick_blank());
    end
    if ($urandom_range(3) == 0) text.push_back(CH_PLUS);
    eff_base = int'(base);
    style = $urandom_range(2);
    if (base == BASE_AUTO) begin
      if (style == 0) begin
        text.push_back(CH_ZERO);
        text.push_back($urandom_range(1) ? CH_LC_X : CH_UC_X);
        eff_base = 16;
      end else if (style == 1) begin
        text.push_back(CH_ZERO);
        eff_base = 8;
      end else begin
        eff_base = 10;
      end
    end else if (base == BASE_HEX && style == 0) begin
      text.push_back(CH_ZERO);
      text.push_back($urandom_range(1) ? CH_LC_X : CH_UC_X);
    end
    n = ($urandom_range(7) == 0) ? $urandom_range(16) : $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      v = $urandom_range(((eff_base > 36) ? 36 : eff_base) - 1);
      // keep auto-decimal from turning into octal
      if (base == BASE_AUTO && style == 2 && i == 0 && v == 0) v = 1;
      text.push_back(digit_char(v));
    end
    text.push_back(CHAR_W'($urandom_range(255)));
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == 0);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_char(CHAR_W'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    logic [BASE_W-1:0] base_pick;
    logic              sgn_pick;
    int                target;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_BASE_SELECT;
    cfg_data  = '0;
    in_valid  = 1'b0;
    ch        = '0;
    start_req = 1'b0;
    out_ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: base ten, unsigned
    send_text("123;");
    send_text(" \t+42\n");
    send_text("-5");
    send_text("  x");
    send_text("4294967296!");
    send_char("7", 1'b0);
    send_text("99");
    send_text("5;");

    // fill the block while results are held back
    drain();
    hold_req = 300;
    repeat (40) begin
      send_char(CH_ZERO + CHAR_W'($urandom_range(9)), 1'b1);
      send_char(CH_SEMI, 1'b0);
    end

    reconfigure(BASE_AUTO, 1'b1);
    send_text(" - 0x1F;");
    send_text("0xg");
    send_text("017 ");
    send_text("08");
    send_text("+ +5,");
    send_text("-+7!");
    send_text("123a");

    reconfigure(BASE_HEX, 1'b0);
    send_text("0XfF.");
    send_text("dead_beef");

    reconfigure(6'd1, 1'b0);
    send_text("0001");

    reconfigure(6'd36, 1'b1);
    send_text("-Zz ");
    send_text("zzzzzzzzzzzz/");

    reconfigure(6'd63, 1'b0);
    send_text("zZ9~");

    reconfigure(6'd2, 1'b1);
    send_text("1012");

    // random phases: none, sender idle, receiver stall, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int s = 0; s < 4; s++) begin
        if ($urandom_range(3) == 0) begin
          base_pick = BASE_W'($urandom_range(63));
        end else begin
          case ($urandom_range(5))
            0: base_pick = BASE_AUTO;
            1: base_pick = 6'd2;
            2: base_pick = BASE_OCT;
            3: base_pick = BASE_DEC;
            4: base_pick = BASE_HEX;
            default: base_pick = 6'd36;
          endcase
        end
        sgn_pick = s[0];
        reconfigure(base_pick, sgn_pick);
        target = chars_sent + 90;
        while (chars_sent < target) begin
          if ($urandom_range(4) == 0) begin
            // noise: random bytes, some restarting mid-conversion
            repeat ($urandom_range(1, 4))
              send_char(CHAR_W'($urandom_range(255)), $urandom_range(3) == 0);
          end else begin
            send_conversion(base_pick, sgn_pick);
          end
        end
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    if (fail_count == 0) begin
      $display("PASS text_to_integer_parser");
    end else begin
      $display("FAIL text_to_integer_parser");
    end
    $finish;
  end

endmodule

[text_to_integer_parser.f]
rtl/tti_pkg.sv
rtl/tti_in_stage.sv
rtl/tti_engine.sv
rtl/text_to_integer_parser.sv
rtl/tti_checker.sv
sim/tti_checker.sv
sim/tb.sv
